// ----- rtl/core/arx_pkg.sv -----
package arx_pkg;

	localparam int NUM_B_TAPS = 4;
	localparam int NUM_A_TAPS = 3;
	localparam int MAX_DELAY  = 12;

	localparam int CTRL_DEPTH = MAX_DELAY + NUM_B_TAPS;
	localparam int CTRL_AW    = $clog2(CTRL_DEPTH);
	localparam int OUT_DEPTH  = 4;
	localparam int OUT_AW     = $clog2(OUT_DEPTH);

	localparam int NUM_REGS = 1 + NUM_B_TAPS + NUM_A_TAPS;
	localparam int CFG_AW   = $clog2(NUM_REGS);
	localparam int CFG_DW   = 16;

	localparam int SAMPLE_W   = 16;
	localparam int COEF_W     = 16;
	localparam int PROD_W     = SAMPLE_W + COEF_W;
	localparam int ACC_W      = PROD_W + 4;
	localparam int FRAC_SHIFT = 14;
	localparam int RQ_W       = ACC_W - FRAC_SHIFT;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [COEF_W-1:0]   coef_t;
	typedef logic [3:0]                 delay_t;
	typedef logic [2:0]                 term_t;
	typedef logic [CFG_AW-1:0]          reg_idx_t;

	// term schedule: noise, then b taps, then a taps
	localparam term_t TERM_NOISE = 3'd0;
	localparam term_t TERM_B0    = 3'd1;
	localparam term_t TERM_A1    = 3'd5;
	localparam term_t TERM_LAST  = 3'd7;

	localparam reg_idx_t REG_DELAY = 3'd0;
	localparam reg_idx_t REG_B0    = 3'd1;
	localparam reg_idx_t REG_A1    = 3'd5;

	localparam delay_t MAX_DELAY_D = 4'(MAX_DELAY);
	localparam coef_t  UNIT_COEF   = 16'sh4000;
	localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(1 << (FRAC_SHIFT - 1));
	localparam sample_t SAT_HI = 16'sh7fff;
	localparam sample_t SAT_LO = 16'sh8000;

	typedef struct packed {
		logic    ctrl_we;
		sample_t ctrl_wdata;
		logic    rd_en;
		term_t   term;
		logic    y_we;
		sample_t y_wdata;
	} hist_req_t;

	typedef struct packed {
		logic  valid;
		term_t term;
	} mac_ctl_t;

endpackage

// ----- rtl/core/arx_stream_if.sv -----
interface arx_in_if;
	logic             valid;
	logic             ready;
	arx_pkg::sample_t control_sample;
	arx_pkg::sample_t noise_sample;

	modport source (output valid, output control_sample, output noise_sample, input ready);
	modport sink   (input valid, input control_sample, input noise_sample, output ready);
endinterface

interface arx_out_if;
	logic             valid;
	logic             ready;
	arx_pkg::sample_t plant_output;

	modport source (output valid, output plant_output, input ready);
	modport sink   (input valid, input plant_output, output ready);
endinterface

// ----- rtl/core/arx_plant_model_step_unit.sv -----
// channel   dir  word fields                         handshake
// samples   in   control_sample, noise_sample (Q8.8)  valid/ready
// results   out  plant_output (Q8.8, saturated)       valid/ready
// cfg       in   cfg_index, cfg_data                  cfg_we, no wait
//
// A new sample can start as the previous one issues its last term; one
// MAC term a cycle through the shared multiplier (noise, four b taps,
// three a taps), history read from two RAMs.
// Reset clears valid bits of both history RAMs at once; no clearing pass.
// A one-word input register and a two-word result queue decouple stalls;
// a new sample starts only while the queue has room for its result.
module arx_plant_model_step_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	arx_in_if.sink                      samples,
	arx_out_if.source                   results,
	input  logic                        cfg_we,
	input  arx_pkg::reg_idx_t           cfg_index,
	input  logic [arx_pkg::CFG_DW-1:0]  cfg_data
);

	arx_pkg::delay_t delay_q;
	arx_pkg::delay_t delay_sat;
	arx_pkg::coef_t  b_q [arx_pkg::NUM_B_TAPS];
	arx_pkg::coef_t  a_q [arx_pkg::NUM_A_TAPS];

	logic             in_full_q;
	arx_pkg::sample_t u_buf_q;
	arx_pkg::sample_t n_buf_q;
	arx_pkg::sample_t noise_q;

	logic              busy_q;
	arx_pkg::term_t    k_q;
	logic              start_en;
	logic              credit_ok;
	logic [1:0]        inflight_q;

	arx_pkg::hist_req_t hreq;
	arx_pkg::sample_t   hsample;
	arx_pkg::mac_ctl_t  ctl_s1;
	arx_pkg::sample_t   y;
	logic               y_valid;

	arx_pkg::sample_t fifo_q [2];
	logic             wr_q;
	logic             rd_q;
	logic [1:0]       cnt_q;
	logic             pop;
	logic             in_acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= '0;
			b_q     <= '{default: '0};
			a_q     <= '{default: '0};
		end else if (cfg_we) begin
			if (cfg_index == arx_pkg::REG_DELAY) begin
				delay_q <= cfg_data[3:0];
			end else if (cfg_index < arx_pkg::REG_A1) begin
				b_q[2'(cfg_index - arx_pkg::REG_B0)] <= cfg_data;
			end else begin
				a_q[2'(cfg_index - arx_pkg::REG_A1)] <= cfg_data;
			end
		end
	end

	assign delay_sat = (delay_q > arx_pkg::MAX_DELAY_D) ? arx_pkg::MAX_DELAY_D : delay_q;

	assign credit_ok = ({1'b0, inflight_q} + {1'b0, cnt_q}) < 3'd2;
	assign start_en  = in_full_q && credit_ok && (!busy_q || (k_q == arx_pkg::TERM_LAST));

	assign samples.ready = !in_full_q || start_en;
	assign in_acc        = samples.valid && samples.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_full_q  <= 1'b0;
			busy_q     <= 1'b0;
			k_q        <= arx_pkg::TERM_NOISE;
			inflight_q <= '0;
			ctl_s1     <= '0;
		end else begin
			if (in_acc) begin
				in_full_q <= 1'b1;
			end else if (start_en) begin
				in_full_q <= 1'b0;
			end
			if (start_en) begin
				busy_q <= 1'b1;
				k_q    <= arx_pkg::TERM_NOISE;
			end else if (busy_q) begin
				if (k_q == arx_pkg::TERM_LAST) begin
					busy_q <= 1'b0;
				end
				k_q <= arx_pkg::term_t'(k_q + 1'b1);
			end
			inflight_q   <= 2'(inflight_q + {1'b0, start_en} - {1'b0, y_valid});
			ctl_s1.valid <= busy_q;
			ctl_s1.term  <= k_q;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			u_buf_q <= samples.control_sample;
			n_buf_q <= samples.noise_sample;
		end
		if (start_en) begin
			noise_q <= n_buf_q;
		end
	end

	always_comb begin
		hreq.ctrl_we    = start_en;
		hreq.ctrl_wdata = u_buf_q;
		hreq.rd_en      = busy_q;
		hreq.term       = k_q;
		hreq.y_we       = y_valid;
		hreq.y_wdata    = y;
	end

	arx_hist u_hist (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (hreq),
		.delay  (delay_sat),
		.sample (hsample)
	);

	arx_mac u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl_s1),
		.sample  (hsample),
		.noise   (noise_q),
		.b_coef  (b_q),
		.a_coef  (a_q),
		.y       (y),
		.y_valid (y_valid)
	);

	assign pop = results.valid && results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (y_valid) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			cnt_q <= 2'(cnt_q + {1'b0, y_valid} - {1'b0, pop});
		end
	end

	always_ff @(posedge clk) begin
		if (y_valid) begin
			fifo_q[wr_q] <= y;
		end
	end

	assign results.valid        = (cnt_q != 2'd0);
	assign results.plant_output = fifo_q[rd_q];

endmodule

// ----- rtl/core/arx_ram.sv -----
module arx_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/core/arx_hist.sv -----
module arx_hist (
	input  logic                clk,
	input  logic                arst_n,
	input  arx_pkg::hist_req_t  req,
	input  arx_pkg::delay_t     delay,
	output arx_pkg::sample_t    sample
);

	logic [arx_pkg::CTRL_AW-1:0]    nw_q;
	logic [arx_pkg::OUT_AW-1:0]     op_q;
	logic [arx_pkg::CTRL_DEPTH-1:0] cvalid_q;
	logic [arx_pkg::OUT_DEPTH-1:0]  ovalid_q;

	logic [arx_pkg::CTRL_AW-1:0] cwaddr;
	logic [arx_pkg::CTRL_AW-1:0] craddr;
	logic [arx_pkg::OUT_AW-1:0]  oraddr;
	logic                        c_re;
	logic                        o_re;
	logic [arx_pkg::SAMPLE_W-1:0] crdata;
	logic [arx_pkg::SAMPLE_W-1:0] ordata;

	logic c_sel_s1;
	logic o_sel_s1;
	logic cval_s1;
	logic oval_s1;

	assign cwaddr = arx_pkg::CTRL_AW'(nw_q + 1'b1);
	assign craddr = arx_pkg::CTRL_AW'(nw_q - arx_pkg::CTRL_AW'(delay)
		- arx_pkg::CTRL_AW'(req.term - arx_pkg::TERM_B0));
	assign oraddr = arx_pkg::OUT_AW'(op_q - arx_pkg::OUT_AW'(req.term - (arx_pkg::TERM_A1 - 3'd1)));

	assign c_re = req.rd_en && (req.term >= arx_pkg::TERM_B0) && (req.term < arx_pkg::TERM_A1);
	assign o_re = req.rd_en && (req.term >= arx_pkg::TERM_A1);

	arx_ram #(.DEPTH(arx_pkg::CTRL_DEPTH), .WIDTH(arx_pkg::SAMPLE_W)) u_ctrl_ram (
		.clk   (clk),
		.we    (req.ctrl_we),
		.waddr (cwaddr),
		.wdata (req.ctrl_wdata),
		.re    (c_re),
		.raddr (craddr),
		.rdata (crdata)
	);

	arx_ram #(.DEPTH(arx_pkg::OUT_DEPTH), .WIDTH(arx_pkg::SAMPLE_W)) u_out_ram (
		.clk   (clk),
		.we    (req.y_we),
		.waddr (op_q),
		.wdata (req.y_wdata),
		.re    (o_re),
		.raddr (oraddr),
		.rdata (ordata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nw_q     <= '0;
			op_q     <= '0;
			cvalid_q <= '0;
			ovalid_q <= '0;
			c_sel_s1 <= 1'b0;
			o_sel_s1 <= 1'b0;
		end else begin
			c_sel_s1 <= c_re;
			o_sel_s1 <= o_re;
			if (req.ctrl_we) begin
				nw_q             <= cwaddr;
				cvalid_q[cwaddr] <= 1'b1;
			end
			if (req.y_we) begin
				op_q           <= arx_pkg::OUT_AW'(op_q + 1'b1);
				ovalid_q[op_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		cval_s1 <= cvalid_q[craddr];
		oval_s1 <= ovalid_q[oraddr];
	end

	// never-written entries read as zero history
	always_comb begin
		sample = '0;
		if (c_sel_s1 && cval_s1) begin
			sample = crdata;
		end else if (o_sel_s1 && oval_s1) begin
			sample = ordata;
		end
	end

endmodule

// ----- rtl/core/arx_mac.sv -----
module arx_mac (
	input  logic               clk,
	input  logic               arst_n,
	input  arx_pkg::mac_ctl_t  ctl,
	input  arx_pkg::sample_t   sample,
	input  arx_pkg::sample_t   noise,
	input  arx_pkg::coef_t     b_coef [arx_pkg::NUM_B_TAPS],
	input  arx_pkg::coef_t     a_coef [arx_pkg::NUM_A_TAPS],
	output arx_pkg::sample_t   y,
	output logic               y_valid
);

	arx_pkg::coef_t   op_coef;
	arx_pkg::sample_t op_x;
	logic signed [arx_pkg::PROD_W-1:0] prod_c;

	logic                              v_s2;
	logic                              sub_s2;
	logic                              first_s2;
	logic                              last_s2;
	logic signed [arx_pkg::PROD_W-1:0] prod_s2;
	logic signed [arx_pkg::ACC_W-1:0]  acc_q;
	logic                              fin_s3;

	logic signed [arx_pkg::ACC_W-1:0] term_ext;
	logic signed [arx_pkg::ACC_W-1:0] acc_base;
	logic signed [arx_pkg::ACC_W-1:0] rnd;
	logic signed [arx_pkg::RQ_W-1:0]  rq;
	logic                             in_range;

	always_comb begin
		op_coef = arx_pkg::UNIT_COEF;
		op_x    = noise;
		if (ctl.term == arx_pkg::TERM_NOISE) begin
			op_coef = arx_pkg::UNIT_COEF;
			op_x    = noise;
		end else if (ctl.term < arx_pkg::TERM_A1) begin
			op_coef = b_coef[2'(ctl.term - arx_pkg::TERM_B0)];
			op_x    = sample;
		end else begin
			op_coef = a_coef[2'(ctl.term - arx_pkg::TERM_A1)];
			op_x    = sample;
		end
	end

	assign prod_c = op_coef * op_x;

	always_ff @(posedge clk) begin
		prod_s2  <= prod_c;
		sub_s2   <= (ctl.term == arx_pkg::TERM_NOISE) || (ctl.term >= arx_pkg::TERM_A1);
		first_s2 <= (ctl.term == arx_pkg::TERM_NOISE);
		last_s2  <= (ctl.term == arx_pkg::TERM_LAST);
		if (v_s2) begin
			acc_q <= sub_s2 ? acc_base - term_ext : acc_base + term_ext;
		end
	end

	assign term_ext = {{(arx_pkg::ACC_W - arx_pkg::PROD_W){prod_s2[arx_pkg::PROD_W-1]}}, prod_s2};
	assign acc_base = first_s2 ? '0 : acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2   <= 1'b0;
			fin_s3 <= 1'b0;
		end else begin
			v_s2   <= ctl.valid;
			fin_s3 <= v_s2 && last_s2;
		end
	end

	// round half up, shift to Q8.8, saturate
	assign rnd      = acc_q + arx_pkg::ROUND_BIAS;
	assign rq       = rnd[arx_pkg::ACC_W-1:arx_pkg::FRAC_SHIFT];
	assign in_range = (&rq[arx_pkg::RQ_W-1:arx_pkg::SAMPLE_W-1])
		|| !(|rq[arx_pkg::RQ_W-1:arx_pkg::SAMPLE_W-1]);

	always_comb begin
		if (in_range) begin
			y = rq[arx_pkg::SAMPLE_W-1:0];
		end else if (rq[arx_pkg::RQ_W-1]) begin
			y = arx_pkg::SAT_LO;
		end else begin
			y = arx_pkg::SAT_HI;
		end
	end

	assign y_valid = fin_s3;

endmodule

// ----- rtl/core/arx_chk.sv -----
module arx_chk (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input arx_pkg::sample_t out_data
);

	logic [2:0] outstanding_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding_q <= '0;
		end else begin
			outstanding_q <= 3'(outstanding_q + {2'b0, in_acc} - {2'b0, out_acc});
		end
	end

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (outstanding_q != 3'd0))
		else $error("result word with no sample outstanding");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(outstanding_q == 3'd0) |-> in_ready)
		else $error("empty block refuses samples");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		outstanding_q <= 3'd3)
		else $error("more words held than buffer space");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (outstanding_q == 3'd0)) |=> !out_valid ##1 !out_valid)
		else $error("result ahead of the MAC pipeline");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
		else $error("stalled result word changed");

endmodule

bind arx_plant_model_step_unit arx_chk u_arx_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (samples.valid),
	.in_ready  (samples.ready),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.out_data  (results.plant_output)
);

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

import arx_pkg::*;

class arx_output_checker;
	delay_t  delay_reg;
	coef_t   b_taps [NUM_B_TAPS];
	coef_t   a_taps [NUM_A_TAPS];
	sample_t ctrl_hist [CTRL_DEPTH];
	sample_t out_hist [NUM_A_TAPS];
	sample_t expected_outputs [$];
	int      errors;

	function new();
		delay_reg = '0;
		foreach (b_taps[i]) b_taps[i] = '0;
		foreach (a_taps[i]) a_taps[i] = '0;
		foreach (ctrl_hist[i]) ctrl_hist[i] = '0;
		foreach (out_hist[i]) out_hist[i] = '0;
		errors = 0;
	endfunction

	function void write_reg(reg_idx_t idx, logic [CFG_DW-1:0] data);
		if (idx == REG_DELAY) begin
			delay_reg = data[3:0];
		end else if (idx < REG_A1) begin
			b_taps[2'(idx - REG_B0)] = data;
		end else begin
			a_taps[2'(idx - REG_A1)] = data;
		end
	endfunction

	function void note_sample(sample_t u, sample_t e);
		longint acc;
		longint y;
		int     d;
		for (int i = CTRL_DEPTH - 1; i > 0; i--)
			ctrl_hist[i] = ctrl_hist[i-1];
		ctrl_hist[0] = u;
		d = (delay_reg > MAX_DELAY) ? MAX_DELAY : int'(delay_reg);
		acc = 0;
		for (int i = 0; i < NUM_B_TAPS; i++)
			if (d + i < CTRL_DEPTH)
				acc += longint'(b_taps[i]) * longint'(ctrl_hist[d+i]);
		for (int j = 0; j < NUM_A_TAPS; j++)
			acc -= longint'(a_taps[j]) * longint'(out_hist[j]);
		acc -= longint'(e) * 16384;
		y = (acc + 8192) >>> FRAC_SHIFT;
		if (y > 32767)
			y = 32767;
		if (y < -32768)
			y = -32768;
		for (int j = NUM_A_TAPS - 1; j > 0; j--)
			out_hist[j] = out_hist[j-1];
		out_hist[0] = sample_t'(y);
		expected_outputs = {expected_outputs, sample_t'(y)};
	endfunction

	function void check_output(sample_t actual);
		sample_t exp_y;
		if (expected_outputs.size() == 0) begin
			$display("%0t: unexpected plant_output word, expected none, actual %0d",
				$time, actual);
			errors++;
		end else begin
			exp_y = expected_outputs.pop_front();
			if (actual !== exp_y) begin
				$display("%0t: plant_output mismatch, expected %0d, actual %0d",
					$time, exp_y, actual);
				errors++;
			end
		end
	endfunction

	function int pending();
		return expected_outputs.size();
	endfunction
endclass

module tb_top;
	logic clk;
	logic arst_n;
	logic cfg_we;
	reg_idx_t cfg_index;
	logic [CFG_DW-1:0] cfg_data;
	bit no_gaps;
	int out_stall;

	arx_in_if  samples ();
	arx_out_if results ();

	arx_output_checker sb;

	arx_plant_model_step_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.samples   (samples.sink),
		.results   (results.source),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

	function automatic int rand_gap();
		int r;
		r = $urandom_range(99);
		if (no_gaps || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(3, 1);
		if (r < 98)
			return $urandom_range(12, 4);
		return $urandom_range(60, 20);
	endfunction

	function automatic sample_t rand_sample();
		int r;
		r = $urandom_range(9);
		case (r)
			0: return SAT_HI;
			1: return SAT_LO;
			2, 3, 4: return sample_t'($urandom_range(1023) - 512);
			default: return sample_t'($urandom);
		endcase
	endfunction

	function automatic coef_t rand_coef(bit feedback);
		int r;
		r = $urandom_range(9);
		if (feedback && $urandom_range(3) != 0)
			return coef_t'($urandom_range(4095) - 2048);
		case (r)
			0: return '0;
			1: return 16'sh7fff;
			2: return 16'sh8000;
			3: return UNIT_COEF;
			4, 5: return coef_t'($urandom_range(8191) - 4096);
			default: return coef_t'($urandom);
		endcase
	endfunction

	// called at a falling edge, returns at a falling edge
	task automatic program_regs(logic [CFG_DW-1:0] d, logic [CFG_DW-1:0] b0,
			logic [CFG_DW-1:0] b1, logic [CFG_DW-1:0] b2, logic [CFG_DW-1:0] b3,
			logic [CFG_DW-1:0] a1, logic [CFG_DW-1:0] a2, logic [CFG_DW-1:0] a3);
		logic [CFG_DW-1:0] vals [NUM_REGS];
		vals[0] = d;
		vals[1] = b0;
		vals[2] = b1;
		vals[3] = b2;
		vals[4] = b3;
		vals[5] = a1;
		vals[6] = a2;
		vals[7] = a3;
		for (int i = 0; i < NUM_REGS; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= reg_idx_t'(i);
			cfg_data  <= vals[i];
			@(posedge clk);
			sb.write_reg(reg_idx_t'(i), vals[i]);
			@(negedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic hold_off(int n);
		if (n > 0) begin
			samples.valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	task automatic send_sample(sample_t u, sample_t e);
		samples.valid          <= 1'b1;
		samples.control_sample <= u;
		samples.noise_sample   <= e;
		do @(posedge clk); while (!samples.ready);
		sb.note_sample(u, e);
		@(negedge clk);
	endtask

	task automatic drain();
		samples.valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (30) @(negedge clk);
	endtask

	initial begin
		out_stall = 0;
		results.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (out_stall > 0) begin
				results.ready <= 1'b0;
				out_stall--;
			end else begin
				results.ready <= 1'b1;
				out_stall = rand_gap();
			end
		end
	end

	always @(posedge clk)
		if (arst_n && results.valid && results.ready)
			sb.check_output(results.plant_output);

	initial begin
		logic [CFG_DW-1:0] d_word;
		sb = new();
		no_gaps = 1'b1;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		samples.valid = 1'b0;
		samples.control_sample = '0;
		samples.noise_sample = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: output is the negated noise, saturating at the top
		send_sample(SAT_HI, SAT_LO);
		send_sample(SAT_LO, SAT_HI);
		send_sample(16'sd0, 16'sd0);
		send_sample(16'sd1, 16'sd1);
		drain();

		program_regs(16'h0000, UNIT_COEF, 16'h0000, 16'h0000, 16'h0000,
			16'h0000, 16'h0000, 16'h0000);
		send_sample(SAT_HI, 16'sd0);
		send_sample(SAT_LO, 16'sd0);
		send_sample(16'sh0080, 16'sh0040);
		send_sample(SAT_LO, SAT_HI);
		drain();

		// rounding of exact halves and of values just off them
		program_regs(16'hfff0, 16'sd1, 16'h0000, 16'h0000, 16'h0000,
			16'h0000, 16'h0000, 16'h0000);
		send_sample(16'sd8192, 16'sd0);
		send_sample(-16'sd8192, 16'sd0);
		send_sample(16'sd8191, 16'sd0);
		send_sample(-16'sd8193, 16'sd0);
		drain();

		// delay above the limit, extreme taps, saturating feedback
		program_regs(16'h000d, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
			16'h8000, 16'h7fff, 16'h8000);
		send_sample(SAT_HI, SAT_LO);
		send_sample(SAT_LO, SAT_HI);
		send_sample(SAT_HI, SAT_HI);
		send_sample(SAT_LO, SAT_LO);
		send_sample(16'sd0, 16'sd0);
		send_sample(SAT_HI, 16'sd0);
		drain();

		program_regs(16'h000c, 16'h0000, 16'h0000, 16'h0000, UNIT_COEF,
			16'h0000, 16'h0000, 16'h0000);
		send_sample(16'sd100, 16'sd0);
		send_sample(-16'sd100, 16'sd0);
		send_sample(SAT_HI, 16'sd0);
		send_sample(SAT_LO, 16'sd0);
		drain();

		for (int ph = 0; ph < 11; ph++) begin
			no_gaps = (ph == 3);
			case (ph)
				0: d_word = 16'h0000;
				1: d_word = 16'hffff;
				2: d_word = {12'($urandom_range(4095)), 4'd12};
				default: d_word = {12'($urandom_range(4095)), 4'($urandom_range(15))};
			endcase
			program_regs(d_word, rand_coef(1'b0), rand_coef(1'b0), rand_coef(1'b0),
				rand_coef(1'b0), rand_coef(1'b1), rand_coef(1'b1), rand_coef(1'b1));
			for (int k = 0; k < 78; k++) begin
				hold_off(rand_gap());
				send_sample(rand_sample(), rand_sample());
			end
			drain();
		end

		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule
